// File: rtl/sfd_pkg.sv
package sfd_pkg;

  localparam int unsigned STORE_DEPTH = 64;
  localparam int unsigned LEN_W       = 7;

  localparam logic [7:0] SLIP_END     = 8'hC0;
  localparam logic [7:0] SLIP_ESC     = 8'hDB;
  localparam logic [7:0] SLIP_ESC_END = 8'hDC;
  localparam logic [7:0] SLIP_ESC_ESC = 8'hDD;

  typedef enum logic [1:0] {
    PH_HUNT,
    PH_COLLECT,
    PH_ESCAPE
  } phase_e;

  typedef enum logic [1:0] {
    CMD_STORE,
    CMD_CLEAR,
    CMD_CLOSE
  } cmd_op_e;

  typedef struct packed {
    cmd_op_e    op;
    logic [7:0] data;
  } cmd_t;

endpackage

// File: rtl/sfd_if.sv
interface sfd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sfd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       last_byte;
  logic [6:0] frame_length;
  logic       overflowed;

  modport source (output valid, output frame_byte, output last_byte,
                  output frame_length, output overflowed, input ready);
  modport sink   (input valid, input frame_byte, input last_byte,
                  input frame_length, input overflowed, output ready);
endinterface

// File: rtl/sfd_front.sv
module sfd_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  sfd_in_if.sink        rx_i,
  input  logic          cmd_full_i,
  output logic          cmd_push_o,
  output sfd_pkg::cmd_t cmd_o
);
  import sfd_pkg::*;

  phase_e phase_q, phase_d;
  logic   need_cmd;
  logic   accept;

  assign rx_i.ready = !cmd_full_i;
  assign accept     = rx_i.valid && !cmd_full_i;
  assign cmd_push_o = accept && need_cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT;
    end else if (accept) begin
      phase_q <= phase_d;
    end
  end

  always_comb begin
    phase_d     = PH_HUNT;
    need_cmd    = 1'b0;
    cmd_o.op    = CMD_STORE;
    cmd_o.data  = rx_i.rx_byte;
    case (phase_q)
      PH_COLLECT: begin
        if (rx_i.rx_byte == SLIP_END) begin
          need_cmd = 1'b1;
          cmd_o.op = CMD_CLOSE;
          phase_d  = PH_HUNT;
        end else if (rx_i.rx_byte == SLIP_ESC) begin
          phase_d = PH_ESCAPE;
        end else begin
          need_cmd = 1'b1;
          phase_d  = PH_COLLECT;
        end
      end
      PH_ESCAPE: begin
        if (rx_i.rx_byte == SLIP_ESC_END) begin
          need_cmd   = 1'b1;
          cmd_o.data = SLIP_END;
          phase_d    = PH_COLLECT;
        end else if (rx_i.rx_byte == SLIP_ESC_ESC) begin
          need_cmd   = 1'b1;
          cmd_o.data = SLIP_ESC;
          phase_d    = PH_COLLECT;
        end else begin
          // bad escape: drop the frame
          need_cmd = 1'b1;
          cmd_o.op = CMD_CLEAR;
          phase_d  = PH_HUNT;
        end
      end
      default: begin
        if (rx_i.rx_byte == SLIP_END) begin
          need_cmd = 1'b1;
          cmd_o.op = CMD_CLEAR;
          phase_d  = PH_COLLECT;
        end
      end
    endcase
  end

endmodule

// File: rtl/sfd_cmd_fifo.sv
module sfd_cmd_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  sfd_pkg::cmd_t push_cmd_i,
  output logic          full_o,
  output logic          pop_valid_o,
  input  logic          pop_ready_i,
  output sfd_pkg::cmd_t pop_cmd_o
);
  import sfd_pkg::*;

  cmd_t       slot_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_push, do_pop;

  assign full_o      = (cnt_q == 2'd2);
  assign pop_valid_o = (cnt_q != 2'd0);
  assign pop_cmd_o   = slot_q[rd_ptr_q];
  assign do_push     = push_i && !full_o;
  assign do_pop      = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = do_push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? !rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

// File: rtl/sfd_back.sv
module sfd_back #(
  parameter int unsigned StoreDepth = sfd_pkg::STORE_DEPTH
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cmd_valid_i,
  output logic          cmd_ready_o,
  input  sfd_pkg::cmd_t cmd_i,
  sfd_out_if.source     fr_o
);
  import sfd_pkg::*;

  localparam int unsigned AW = (StoreDepth > 1) ? $clog2(StoreDepth) : 1;
  localparam int unsigned CW = $clog2(StoreDepth + 1);

  logic [7:0]       mem_q [StoreDepth];
  logic [CW-1:0]    cnt_q;
  logic             ovf_q;
  logic             emit_q;
  logic [AW-1:0]    rd_idx_q;
  logic             out_valid_q;
  logic [7:0]       byte_q;
  logic             last_q;
  logic [LEN_W-1:0] len_q;
  logic             ovfl_q;
  logic             out_free;
  logic             is_last;
  logic             take_cmd;

  assign out_free    = !out_valid_q || fr_o.ready;
  assign is_last     = (CW'(rd_idx_q) == (cnt_q - CW'(1)));
  assign cmd_ready_o = !emit_q;
  assign take_cmd    = cmd_valid_i && !emit_q;

  assign fr_o.valid        = out_valid_q;
  assign fr_o.frame_byte   = byte_q;
  assign fr_o.last_byte    = last_q;
  assign fr_o.frame_length = len_q;
  assign fr_o.overflowed   = ovfl_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      ovf_q       <= 1'b0;
      emit_q      <= 1'b0;
      rd_idx_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (emit_q && out_free) begin
        out_valid_q <= 1'b1;
        if (is_last) begin
          emit_q <= 1'b0;
          cnt_q  <= '0;
          ovf_q  <= 1'b0;
        end else begin
          rd_idx_q <= rd_idx_q + AW'(1);
        end
      end else if (fr_o.ready) begin
        out_valid_q <= 1'b0;
      end

      if (take_cmd) begin
        case (cmd_i.op)
          CMD_STORE: begin
            if (cnt_q < CW'(StoreDepth)) begin
              cnt_q <= cnt_q + CW'(1);
            end else begin
              ovf_q <= 1'b1;
            end
          end
          CMD_CLOSE: begin
            if (cnt_q != '0) begin
              emit_q   <= 1'b1;
              rd_idx_q <= '0;
            end
          end
          default: begin
            cnt_q <= '0;
            ovf_q <= 1'b0;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_cmd && cmd_i.op == CMD_STORE && cnt_q < CW'(StoreDepth)) begin
      mem_q[cnt_q[AW-1:0]] <= cmd_i.data;
    end
    if (emit_q && out_free) begin
      byte_q <= mem_q[rd_idx_q];
      last_q <= is_last;
      len_q  <= LEN_W'(cnt_q);
      ovfl_q <= ovf_q;
    end
  end

endmodule

// File: rtl/slip_frame_decoder.sv
// SLIP receive deframer. Raw serial words enter on rx_i; each completed,
// non-empty frame leaves on fr_o one decoded word per handshake, with the
// final word marked and every word carrying the frame length and an overflow
// flag. An input word is taken whenever the two-entry command
// queue between the front classifier and the frame store has room. A closing
// delimiter makes the store stream the frame out through its single read port
// at one word per cycle while fr_o is not held off by ready low;
// meanwhile input keeps being taken until the queue holds two commands.
// Words past StoreDepth are dropped and flagged; empty frames and bad
// escapes produce nothing. No clearing pass is needed after reset.
module slip_frame_decoder #(
  parameter int unsigned StoreDepth = sfd_pkg::STORE_DEPTH
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  sfd_in_if.sink    rx_i,
  sfd_out_if.source fr_o
);
  import sfd_pkg::*;

  logic cmd_full;
  logic cmd_push;
  cmd_t cmd_in;
  logic cmd_valid;
  logic cmd_ready;
  cmd_t cmd_out;

  sfd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rx_i       (rx_i),
    .cmd_full_i (cmd_full),
    .cmd_push_o (cmd_push),
    .cmd_o      (cmd_in)
  );

  sfd_cmd_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (cmd_push),
    .push_cmd_i  (cmd_in),
    .full_o      (cmd_full),
    .pop_valid_o (cmd_valid),
    .pop_ready_i (cmd_ready),
    .pop_cmd_o   (cmd_out)
  );

  sfd_back #(
    .StoreDepth (StoreDepth)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_ready_o (cmd_ready),
    .cmd_i       (cmd_out),
    .fr_o        (fr_o)
  );

endmodule

// File: tb/sfd_checker.sv
module sfd_checker (
  input  logic clk_i,
  input  logic rst_ni,
  sfd_in_if    rx_mon,
  sfd_out_if   fr_mon,
  output int   mismatch_o,
  output int   pending_o
);
  import sfd_pkg::*;

  localparam int unsigned IDX_W = $clog2(STORE_DEPTH);

  typedef struct packed {
    logic [7:0]       data;
    logic             last;
    logic [LEN_W-1:0] length;
    logic             ovf;
  } frame_word_t;

  frame_word_t      frame_words_q[$];
  phase_e           rx_phase;
  logic [7:0]       payload_mem [STORE_DEPTH];
  logic [LEN_W-1:0] payload_cnt;
  logic             payload_ovf;
  int               mismatches = 0;

  task automatic keep_payload(input logic [7:0] b);
    if (payload_cnt < STORE_DEPTH) begin
      payload_mem[payload_cnt[IDX_W-1:0]] = b;
      payload_cnt = payload_cnt + 1'b1;
    end else begin
      payload_ovf = 1'b1;
    end
  endtask

  task automatic release_frame();
    frame_word_t w;
    for (int k = 0; k < payload_cnt; k++) begin
      w.data   = payload_mem[k[IDX_W-1:0]];
      w.last   = (k == payload_cnt - 1);
      w.length = payload_cnt;
      w.ovf    = payload_ovf;
      frame_words_q.push_back(w);
    end
  endtask

  task automatic drop_payload();
    payload_cnt = '0;
    payload_ovf = 1'b0;
  endtask

  task automatic deframe_word(input logic [7:0] b);
    case (rx_phase)
      PH_COLLECT: begin
        if (b == SLIP_END) begin
          if (payload_cnt != 0) release_frame();
          drop_payload();
          rx_phase = PH_HUNT;
        end else if (b == SLIP_ESC) begin
          rx_phase = PH_ESCAPE;
        end else begin
          keep_payload(b);
        end
      end
      PH_ESCAPE: begin
        if (b == SLIP_ESC_END) begin
          keep_payload(SLIP_END);
          rx_phase = PH_COLLECT;
        end else if (b == SLIP_ESC_ESC) begin
          keep_payload(SLIP_ESC);
          rx_phase = PH_COLLECT;
        end else begin
          drop_payload();
          rx_phase = PH_HUNT;
        end
      end
      default: begin
        if (b == SLIP_END) begin
          drop_payload();
          rx_phase = PH_COLLECT;
        end else begin
          rx_phase = PH_HUNT;
        end
      end
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    frame_word_t got;
    frame_word_t want;
    if (!rst_ni) begin
      rx_phase = PH_HUNT;
      drop_payload();
      frame_words_q.delete();
      mismatches = 0;
    end else begin
      if (rx_mon.valid && rx_mon.ready) deframe_word(rx_mon.rx_byte);
      if (fr_mon.valid && fr_mon.ready) begin
        got.data   = fr_mon.frame_byte;
        got.last   = fr_mon.last_byte;
        got.length = fr_mon.frame_length;
        got.ovf    = fr_mon.overflowed;
        if (frame_words_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected word: data %h last %b len %0d ovf %b",
                     got.data, got.last, got.length, got.ovf);
        end else begin
          want = frame_words_q.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("word mismatch: exp data %h last %b len %0d ovf %b, ",
                       want.data, want.last, want.length, want.ovf,
                       "got data %h last %b len %0d ovf %b",
                       got.data, got.last, got.length, got.ovf);
          end
        end
      end
    end
    mismatch_o <= mismatches;
    pending_o  <= frame_words_q.size();
  end

endmodule

// File: tb/tb_top.sv
module tb_top;
  import sfd_pkg::*;

  localparam int NUM_DIRECTED = 27;
  localparam logic [7:0] DIRECTED [NUM_DIRECTED] = '{
    8'hFF, 8'h00,                                   // noise while hunting
    SLIP_END, SLIP_END,                             // empty frame
    SLIP_END, 8'h00, SLIP_END,                      // one-word frame
    8'h55,                                          // closing END does not reopen
    SLIP_END, 8'hFF, SLIP_ESC, SLIP_ESC_END, SLIP_ESC, SLIP_ESC_ESC, SLIP_END,
    SLIP_END, 8'h12, SLIP_ESC, 8'h34,               // bad escape
    8'h56, SLIP_END, 8'hAA, SLIP_END,
    SLIP_END, 8'h01, SLIP_ESC, SLIP_END             // END after ESC is a bad escape
  };

  logic clk_i = 1'b0;
  logic rst_ni;

  sfd_in_if  rx_if();
  sfd_out_if fr_if();

  int mismatch_cnt;
  int words_pending;
  int words_sent = 0;
  int stall_left = 0;
  bit idle_en    = 1'b1;
  bit quiet      = 1'b0;

  always #10 clk_i = ~clk_i;

  slip_frame_decoder i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rx_i   (rx_if.sink),
    .fr_o   (fr_if.source)
  );

  sfd_checker i_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rx_mon     (rx_if),
    .fr_mon     (fr_if),
    .mismatch_o (mismatch_cnt),
    .pending_o  (words_pending)
  );

  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      fr_if.ready <= 1'b0;
      stall_left  <= stall_left - 1;
    end else if (idle_en && !quiet && $urandom_range(0, 4) == 0) begin
      fr_if.ready <= 1'b0;
      stall_left  <= $urandom_range(0, 2);
    end else begin
      fr_if.ready <= 1'b1;
    end
  end

  task automatic send_word(input logic [7:0] b);
    if (idle_en && !quiet && $urandom_range(0, 3) == 0) begin
      rx_if.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    rx_if.valid   <= 1'b1;
    rx_if.rx_byte <= b;
    @(posedge clk_i);
    while (!rx_if.ready) @(posedge clk_i);
    words_sent++;
  endtask

  task automatic drain();
    rx_if.valid <= 1'b0;
    @(posedge clk_i);
    while (words_pending != 0) @(posedge clk_i);
  endtask

  task automatic send_frame(input int len, input bit bad_esc);
    logic [7:0] b;
    logic [7:0] junk;
    send_word(SLIP_END);
    for (int i = 0; i < len; i++) begin
      case ($urandom_range(0, 7))
        0:       b = SLIP_END;
        1:       b = SLIP_ESC;
        2:       b = ($urandom_range(0, 1) != 0) ? SLIP_ESC_END : SLIP_ESC_ESC;
        default: b = 8'($urandom_range(0, 255));
      endcase
      if (b == SLIP_END) begin
        send_word(SLIP_ESC);
        send_word(SLIP_ESC_END);
      end else if (b == SLIP_ESC) begin
        send_word(SLIP_ESC);
        send_word(SLIP_ESC_ESC);
      end else begin
        send_word(b);
      end
      if (bad_esc && i == len / 2) begin
        do junk = 8'($urandom_range(0, 255));
        while (junk == SLIP_ESC_END || junk == SLIP_ESC_ESC);
        send_word(SLIP_ESC);
        send_word(junk);
      end
    end
    send_word(SLIP_END);
  endtask

  initial begin
    int kind;
    int len;
    rst_ni        <= 1'b0;
    rx_if.valid   <= 1'b0;
    rx_if.rx_byte <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < NUM_DIRECTED; i++) send_word(DIRECTED[i]);
    drain();

    // full store, then overflow
    send_frame(64, 1'b0);
    send_frame(66, 1'b0);

    while (words_sent < 270) begin
      if (words_sent > 220) quiet = 1'b1;
      if ($urandom_range(0, 9) == 0) idle_en = ($urandom_range(0, 2) != 0);
      kind = $urandom_range(0, 9);
      if (kind < 7) begin
        len = ($urandom_range(0, 19) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 8);
        send_frame(len, 1'b0);
      end else if (kind == 7) begin
        send_frame($urandom_range(1, 6), 1'b1);
      end else if (kind == 8) begin
        repeat ($urandom_range(1, 4)) send_word(8'($urandom_range(0, 255)));
      end else begin
        send_word(SLIP_END);
        send_word(SLIP_END);
      end
      if ($urandom_range(0, 29) == 0) drain();
    end

    drain();
    repeat (80) @(posedge clk_i);
    if (mismatch_cnt == 0 && words_pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("Mismatches found");
    $finish;
  end

endmodule

// File: sim.f
rtl/sfd_pkg.sv
rtl/sfd_if.sv
rtl/sfd_front.sv
rtl/sfd_cmd_fifo.sv
rtl/sfd_back.sv
rtl/slip_frame_decoder.sv
tb/sfd_checker.sv
tb/tb_top.sv
